/* hdl/amuce_pkg.sv */
`default_nettype none

package amuce_pkg;

    // Frame constants
    localparam logic [7:0] START_BYTE   = 8'd126;
    localparam logic [7:0] VERSION_BYTE = 8'd255;
    localparam logic [7:0] LENGTH_BYTE  = 8'd6;
    localparam logic [7:0] END_BYTE     = 8'd239;

    localparam int FRAME_LEN = 10;
    localparam int BYTE_IDX_W = $clog2(FRAME_LEN);

    // Volume ceiling
    localparam logic [4:0] VOLUME_MAX = 5'd30;

    // Register reset values
    localparam logic [15:0] REQ_GAP_RST  = 16'd100;
    localparam logic [15:0] RESP_GAP_RST = 16'd50;
    localparam logic [7:0]  CODE_RESET_RST    = 8'd12;
    localparam logic [7:0]  CODE_VOLUME_RST   = 8'd6;
    localparam logic [7:0]  CODE_STOP_RST     = 8'd22;
    localparam logic [7:0]  CODE_PLAY_RST     = 8'd3;
    localparam logic [7:0]  CODE_STATUS_RST   = 8'd66;
    localparam logic [7:0]  CODE_FEEDBACK_RST = 8'd66;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam logic [15:0] PARAM_PLAYING = 16'd1;

    // Pending request flag positions
    localparam int PF_RESET  = 0;
    localparam int PF_VOLUME = 1;
    localparam int PF_STOP   = 2;
    localparam int PF_PLAY   = 3;
    localparam int PF_STATUS = 4;
    localparam int PF_W      = 5;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQ_GAP   = 3'd0,
        CFG_RESP_GAP  = 3'd1,
        CFG_CODE_RST  = 3'd2,
        CFG_CODE_VOL  = 3'd3,
        CFG_CODE_STOP = 3'd4,
        CFG_CODE_PLAY = 3'd5,
        CFG_CODE_STAT = 3'd6,
        CFG_CODE_FB   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_RX     = 3'd1,
        CMD_RESET  = 3'd2,
        CMD_VOLUME = 3'd3,
        CMD_PLAY   = 3'd4,
        CMD_STOP   = 3'd5
    } command_t;

    typedef enum logic [3:0] {
        PS_START    = 4'd0,
        PS_VERSION  = 4'd1,
        PS_LENGTH   = 4'd2,
        PS_CMD      = 4'd3,
        PS_ACK      = 4'd4,
        PS_PARAM_HI = 4'd5,
        PS_PARAM_LO = 4'd6,
        PS_CS_HI    = 4'd7,
        PS_CS_LO    = 4'd8,
        PS_END      = 4'd9
    } parse_state_t;

    // One unit of back-end work: a whole frame or a status report
    typedef struct packed {
        logic        is_status;
        logic        playing;
        logic [7:0]  cmd;
        logic [15:0] param;
        logic [15:0] csum;
    } job_t;

    // Two's complement of VERSION + LENGTH + cmd + ack + param, 16 bits
    function automatic logic [15:0] frame_csum(input logic [7:0] cmd,
                                               input logic [7:0] ack,
                                               input logic [15:0] param);
        logic [15:0] sum;
        sum = {8'd0, VERSION_BYTE} + {8'd0, LENGTH_BYTE} + {8'd0, cmd}
            + {8'd0, ack} + param;
        return 16'd0 - sum;
    endfunction

endpackage

`default_nettype wire

/* hdl/amuce_fifo.sv */
`default_nettype none

module amuce_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire amuce_pkg::job_t  push_job,
    input  wire logic             pop,
    output amuce_pkg::job_t       head_job,
    output logic                  empty,
    output logic                  full
);
    import amuce_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_job = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/amuce_front.sv */
`default_nettype none

module amuce_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [amuce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [amuce_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [2:0]                      s_command,
    input  wire logic [15:0]                     s_value,
    input  wire logic                            q_full,
    output logic                                 push,
    output amuce_pkg::job_t                      push_job
);
    import amuce_pkg::*;

    // Configuration registers
    logic [15:0] req_gap_reg, resp_gap_reg;
    logic [7:0]  code_reset_reg, code_volume_reg, code_stop_reg;
    logic [7:0]  code_play_reg, code_status_reg, code_feedback_reg;

    // Engine state
    logic [PF_W-1:0] pending_reg, pending_next;
    logic            init_reg, init_next;
    logic [4:0]      volume_reg, volume_next;
    logic [15:0]     track_reg, track_next;
    logic [15:0]     since_req_reg, since_req_next;
    logic [15:0]     since_resp_reg, since_resp_next;
    parse_state_t    pstate_reg, pstate_next;
    logic [7:0]      rx_cmd_reg, rx_cmd_next;
    logic [7:0]      rx_ack_reg, rx_ack_next;
    logic [15:0]     rx_param_reg, rx_param_next;
    logic [15:0]     rx_cs_reg, rx_cs_next;
    logic            playing_reg, playing_next;

    logic        accept;
    logic [15:0] req_inc, resp_inc;
    logic        gaps_ok;
    logic [7:0]  rx_byte;
    logic [15:0] cs_full;
    logic [7:0]  job_cmd;
    logic [15:0] job_param;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign rx_byte = s_value[7:0];

    // Saturating gap counters and gap test for ticks
    assign req_inc  = (since_req_reg  == CNT_MAX) ? since_req_reg  : since_req_reg  + 16'd1;
    assign resp_inc = (since_resp_reg == CNT_MAX) ? since_resp_reg : since_resp_reg + 16'd1;
    assign gaps_ok  = (req_inc > req_gap_reg) && (resp_inc > resp_gap_reg);
    assign cs_full  = {rx_cs_reg[15:8], rx_byte};

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_gap_reg       <= REQ_GAP_RST;
            resp_gap_reg      <= RESP_GAP_RST;
            code_reset_reg    <= CODE_RESET_RST;
            code_volume_reg   <= CODE_VOLUME_RST;
            code_stop_reg     <= CODE_STOP_RST;
            code_play_reg     <= CODE_PLAY_RST;
            code_status_reg   <= CODE_STATUS_RST;
            code_feedback_reg <= CODE_FEEDBACK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_REQ_GAP:   req_gap_reg       <= cfg_wdata;
                CFG_RESP_GAP:  resp_gap_reg      <= cfg_wdata;
                CFG_CODE_RST:  code_reset_reg    <= cfg_wdata[7:0];
                CFG_CODE_VOL:  code_volume_reg   <= cfg_wdata[7:0];
                CFG_CODE_STOP: code_stop_reg     <= cfg_wdata[7:0];
                CFG_CODE_PLAY: code_play_reg     <= cfg_wdata[7:0];
                CFG_CODE_STAT: code_status_reg   <= cfg_wdata[7:0];
                CFG_CODE_FB:   code_feedback_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Event decode: state update and job classification
    always_comb begin
        pending_next    = pending_reg;
        init_next       = init_reg;
        volume_next     = volume_reg;
        track_next      = track_reg;
        since_req_next  = since_req_reg;
        since_resp_next = since_resp_reg;
        pstate_next     = pstate_reg;
        rx_cmd_next     = rx_cmd_reg;
        rx_ack_next     = rx_ack_reg;
        rx_param_next   = rx_param_reg;
        rx_cs_next      = rx_cs_reg;
        playing_next    = playing_reg;
        push            = 1'b0;
        job_cmd         = code_status_reg;
        job_param       = 16'd0;
        push_job.is_status = 1'b0;
        push_job.playing   = 1'b0;

        if (accept) begin
            case (s_command)
                CMD_TICK: begin
                    since_req_next  = req_inc;
                    since_resp_next = resp_inc;
                    if (gaps_ok) begin
                        push = 1'b1;
                        if (pending_reg[PF_RESET]) begin
                            pending_next[PF_RESET] = 1'b0;
                            job_cmd = code_reset_reg;
                        end else if (init_reg && pending_reg[PF_VOLUME]) begin
                            pending_next[PF_VOLUME] = 1'b0;
                            job_cmd   = code_volume_reg;
                            job_param = {11'd0, volume_reg};
                        end else if (init_reg && pending_reg[PF_STOP]) begin
                            pending_next[PF_STOP] = 1'b0;
                            job_cmd = code_stop_reg;
                        end else if (init_reg && pending_reg[PF_PLAY]) begin
                            pending_next[PF_PLAY] = 1'b0;
                            job_cmd   = code_play_reg;
                            job_param = track_reg;
                        end else if (pending_reg[PF_STATUS]) begin
                            pending_next[PF_STATUS] = 1'b0;
                            job_cmd = code_status_reg;
                        end else begin
                            push = 1'b0;
                        end
                        if (push) begin
                            since_req_next = 16'd0;
                        end
                    end
                end
                CMD_RX: begin
                    case (pstate_reg)
                        PS_START:    pstate_next = (rx_byte == START_BYTE) ? PS_VERSION
                                                                          : PS_START;
                        PS_VERSION:  pstate_next = (rx_byte == VERSION_BYTE) ? PS_LENGTH
                                                                            : PS_START;
                        PS_LENGTH:   pstate_next = (rx_byte == LENGTH_BYTE) ? PS_CMD
                                                                           : PS_START;
                        PS_CMD: begin
                            rx_cmd_next = rx_byte;
                            pstate_next = PS_ACK;
                        end
                        PS_ACK: begin
                            rx_ack_next = rx_byte;
                            pstate_next = PS_PARAM_HI;
                        end
                        PS_PARAM_HI: begin
                            rx_param_next = {rx_byte, rx_param_reg[7:0]};
                            pstate_next   = PS_PARAM_LO;
                        end
                        PS_PARAM_LO: begin
                            rx_param_next = {rx_param_reg[15:8], rx_byte};
                            pstate_next   = PS_CS_HI;
                        end
                        PS_CS_HI: begin
                            rx_cs_next  = {rx_byte, rx_cs_reg[7:0]};
                            pstate_next = PS_CS_LO;
                        end
                        PS_CS_LO: begin
                            rx_cs_next  = cs_full;
                            pstate_next = (cs_full == frame_csum(rx_cmd_reg, rx_ack_reg,
                                                                 rx_param_reg))
                                        ? PS_END : PS_START;
                        end
                        PS_END: begin
                            pstate_next = PS_START;
                            if (rx_byte == END_BYTE) begin
                                init_next       = 1'b1;
                                since_resp_next = 16'd0;
                                if (rx_cmd_reg == code_feedback_reg) begin
                                    playing_next = (rx_param_reg == PARAM_PLAYING);
                                    if (rx_param_reg == PARAM_PLAYING) begin
                                        pending_next[PF_STATUS] = 1'b1;
                                    end
                                    push = 1'b1;
                                    push_job.is_status = 1'b1;
                                    push_job.playing   = (rx_param_reg == PARAM_PLAYING);
                                end
                            end
                        end
                        default: pstate_next = PS_START;
                    endcase
                end
                CMD_RESET: pending_next[PF_RESET] = 1'b1;
                CMD_VOLUME: begin
                    volume_next = (s_value <= {11'd0, VOLUME_MAX}) ? s_value[4:0]
                                                                   : VOLUME_MAX;
                    pending_next[PF_VOLUME] = 1'b1;
                end
                CMD_PLAY: begin
                    track_next = s_value;
                    pending_next[PF_PLAY] = 1'b1;
                end
                CMD_STOP: begin
                    pending_next[PF_PLAY] = 1'b0;
                    pending_next[PF_STOP] = 1'b1;
                end
                default: ;
            endcase
        end

        push_job.cmd   = job_cmd;
        push_job.param = job_param;
        push_job.csum  = frame_csum(job_cmd, 8'd0, job_param);
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg    <= PF_W'((1 << PF_RESET) | (1 << PF_STATUS));
            init_reg       <= 1'b0;
            volume_reg     <= VOLUME_MAX;
            track_reg      <= 16'd0;
            since_req_reg  <= 16'd0;
            since_resp_reg <= 16'd0;
            pstate_reg     <= PS_START;
            rx_cmd_reg     <= 8'd0;
            rx_ack_reg     <= 8'd0;
            rx_param_reg   <= 16'd0;
            rx_cs_reg      <= 16'd0;
            playing_reg    <= 1'b0;
        end else begin
            pending_reg    <= pending_next;
            init_reg       <= init_next;
            volume_reg     <= volume_next;
            track_reg      <= track_next;
            since_req_reg  <= since_req_next;
            since_resp_reg <= since_resp_next;
            pstate_reg     <= pstate_next;
            rx_cmd_reg     <= rx_cmd_next;
            rx_ack_reg     <= rx_ack_next;
            rx_param_reg   <= rx_param_next;
            rx_cs_reg      <= rx_cs_next;
            playing_reg    <= playing_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/amuce_back.sv */
`default_nettype none

module amuce_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire amuce_pkg::job_t head_job,
    input  wire logic            q_empty,
    output logic                 pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic                 m_kind,
    output logic [7:0]           m_tx_byte,
    output logic                 m_playing,
    output logic                 m_last
);
    import amuce_pkg::*;

    logic [BYTE_IDX_W-1:0] idx_reg;
    logic                  m_valid_reg;
    logic                  kind_reg, playing_reg, last_reg;
    logic [7:0]            tx_reg;

    logic                  load;
    logic                  is_last;
    logic [7:0]            frame_byte;

    assign load    = !q_empty && (!m_valid_reg || m_ready);
    assign is_last = head_job.is_status || (idx_reg == BYTE_IDX_W'(FRAME_LEN - 1));
    assign pop     = load && is_last;

    // Frame byte for the current position
    always_comb begin
        case (idx_reg)
            4'd0:    frame_byte = START_BYTE;
            4'd1:    frame_byte = VERSION_BYTE;
            4'd2:    frame_byte = LENGTH_BYTE;
            4'd3:    frame_byte = head_job.cmd;
            4'd4:    frame_byte = 8'd0;
            4'd5:    frame_byte = head_job.param[15:8];
            4'd6:    frame_byte = head_job.param[7:0];
            4'd7:    frame_byte = head_job.csum[15:8];
            4'd8:    frame_byte = head_job.csum[7:0];
            default: frame_byte = END_BYTE;
        endcase
    end

    // Byte sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= is_last ? '0 : idx_reg + 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg    <= head_job.is_status;
            tx_reg      <= head_job.is_status ? 8'd0 : frame_byte;
            playing_reg <= head_job.is_status && head_job.playing;
            last_reg    <= is_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = kind_reg;
    assign m_tx_byte = tx_reg;
    assign m_playing = playing_reg;
    assign m_last    = last_reg;

endmodule

`default_nettype wire

/* hdl/audio_module_uart_command_engine.sv */
// Command engine for a serial MP3 audio module. Input requests carry a tick, a received
// UART byte, or a reset/volume/play/stop request; results are transmit bytes (kind 0) or
// playing status reports (kind 1), with last marking the final result of a request. A
// front end takes one request per cycle while its two-entry job queue has room, updating
// pending flags, gap counters and the receive deframer in that cycle. A back end byte
// sequencer drains the queue at one result per cycle while m_ready accepts, through a
// registered output stage; a tick that sends a frame yields ten transmit bytes and a
// status report one result. Registers are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write them only while the engine is idle; the block does not enforce it.
`default_nettype none

module audio_module_uart_command_engine (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [amuce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [amuce_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [2:0]                       s_command,
    input  wire logic [15:0]                      s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_kind,
    output logic [7:0]                            m_tx_byte,
    output logic                                  m_playing,
    output logic                                  m_last
);
    import amuce_pkg::*;

    logic q_full, q_empty, push, pop;
    job_t push_job, head_job;

    amuce_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_value   (s_value),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    amuce_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    amuce_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (head_job),
        .q_empty   (q_empty),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_tx_byte (m_tx_byte),
        .m_playing (m_playing),
        .m_last    (m_last)
    );

endmodule

`default_nettype wire

/* hdl/amuce_checker.sv */
`default_nettype none

module amuce_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_kind,
    input wire logic [7:0]  m_tx_byte,
    input wire logic        m_playing,
    input wire logic        m_last
);
    import amuce_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_kind)
                                && $stable(m_last))
        else $error("result changed while stalled");

    // Status report is a single, final result with no byte
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_last && (m_tx_byte == 8'd0))
        else $error("malformed status report");

    // Transmit bytes never carry a playing bit
    a_tx_play: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> !m_playing)
        else $error("playing set on transmit byte");

    // The final byte of a frame is the end marker
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind && m_last |-> m_tx_byte == END_BYTE)
        else $error("frame does not close with end byte");

    // No result in the cycle after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind audio_module_uart_command_engine amuce_checker u_amuce_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_kind    (m_kind),
    .m_tx_byte (m_tx_byte),
    .m_playing (m_playing),
    .m_last    (m_last)
);

`default_nettype wire
